>>> hdl/block_buffer_cache_lru_macros.svh
// Assertion macros for the buffer cache.
// Each macro takes a label, a condition pair and a message string.
`ifndef BLOCK_BUFFER_CACHE_LRU_MACROS_SVH
`define BLOCK_BUFFER_CACHE_LRU_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BBC_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BBC_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hdl/bbc_lru_pkg.sv
package bbc_lru_pkg;

   // Sizing of the cache.
   localparam int SLOT_COUNT  = 32;
   localparam int DEVICE_BITS = 8;
   localparam int COUNT_BITS  = 8;
   localparam int SLOT_BITS   = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   // Command codes.
   localparam logic [1:0] CMD_READ    = 2'd0;
   localparam logic [1:0] CMD_RELEASE = 2'd1;
   localparam logic [1:0] CMD_PIN     = 2'd2;
   localparam logic [1:0] CMD_UNPIN   = 2'd3;

   // Status codes.
   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_NO_FREE   = 2'd1;
   localparam logic [1:0] STATUS_UNDERFLOW = 2'd2;

   typedef struct packed {
      logic [1:0]  command;
      logic [7:0]  device;
      logic [31:0] block_number;
      logic [4:0]  slot_in;
   } req_type;

   typedef struct packed {
      logic [4:0] slot_out;
      logic       hit;
      logic       needs_fill;
      logic [1:0] status;
      logic [7:0] count_after;
   } rsp_type;

endpackage

>>> hdl/block_buffer_cache_lru.sv
// Channel    | Ports                        | Handshake
// -----------+------------------------------+-------------------------------------
// request    | start, busy, req_item        | word taken when start && !busy
// response   | rsp_valid, rsp_item          | word present for one cycle, no stall
//
// A read walks the recency list one slot per cycle, most recent first, and
// stops at a hit or after the last rank. Release, pin and unpin go from idle
// straight to the update state. The shared tag and count comparator in the
// walk sets the read latency. Reset clears all tags, counts and valid bits
// and restores the initial recency order. The response cannot be stalled;
// busy stays high from acceptance until the strobe cycle.
`include "block_buffer_cache_lru_macros.svh"

module block_buffer_cache_lru (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   output logic                 busy,
   input  bbc_lru_pkg::req_type req_item,
   output logic                 rsp_valid,
   output bbc_lru_pkg::rsp_type rsp_item
);
   import bbc_lru_pkg::*;

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_WALK   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   localparam logic [SLOT_BITS-1:0] LAST_RANK = SLOT_BITS'(SLOT_COUNT - 1);

   // Sequencer and walk state.
   logic [1:0]           state_ff, state_in;
   logic [SLOT_BITS-1:0] idx_ff, idx_in;
   logic                 free_found_ff, free_found_in;
   logic [SLOT_BITS-1:0] free_slot_ff, free_slot_in;

   // Latched request word.
   logic [1:0]             cmd_ff, cmd_in;
   logic [DEVICE_BITS-1:0] dev_ff, dev_in;
   logic [31:0]            blk_ff, blk_in;
   logic [4:0]             slot_raw_ff, slot_raw_in;

   // Per-slot state and the recency list (order_ff[rank] holds a slot).
   logic [DEVICE_BITS-1:0] tag_dev_ff [SLOT_COUNT];
   logic [DEVICE_BITS-1:0] tag_dev_in [SLOT_COUNT];
   logic [31:0]            tag_blk_ff [SLOT_COUNT];
   logic [31:0]            tag_blk_in [SLOT_COUNT];
   logic [COUNT_BITS-1:0]  count_ff   [SLOT_COUNT];
   logic [COUNT_BITS-1:0]  count_in   [SLOT_COUNT];
   logic [SLOT_BITS-1:0]   rank_ff    [SLOT_COUNT];
   logic [SLOT_BITS-1:0]   rank_in    [SLOT_COUNT];
   logic [SLOT_BITS-1:0]   order_ff   [SLOT_COUNT];
   logic [SLOT_BITS-1:0]   order_in   [SLOT_COUNT];
   logic [SLOT_COUNT-1:0]  valid_ff, valid_in;

   // Response register.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_ff, rsp_in;

   // Shared compare unit: one slot per cycle, chosen by rank in a walk.
   logic [SLOT_BITS-1:0]  walk_slot;
   logic [SLOT_BITS-1:0]  op_slot;
   logic [SLOT_BITS-1:0]  cnt_sel;
   logic [COUNT_BITS-1:0] cnt_cur;
   logic [COUNT_BITS-1:0] cnt_inc;
   logic                  tag_match;
   logic                  cnt_zero;

   assign walk_slot = order_ff[idx_ff];
   assign op_slot   = SLOT_BITS'(slot_raw_ff);
   assign cnt_sel   = (state_ff == ST_WALK) ? walk_slot : op_slot;
   assign cnt_cur   = count_ff[cnt_sel];
   assign cnt_inc   = (cnt_cur == COUNT_MAX) ? cnt_cur : cnt_cur + 1'b1;
   assign cnt_zero  = (cnt_cur == '0);
   assign tag_match = (tag_dev_ff[walk_slot] == dev_ff) && (tag_blk_ff[walk_slot] == blk_ff);

   // Sequencer and all state updates.
   always_comb begin
      logic                  fnd;
      logic [SLOT_BITS-1:0]  fslot;
      logic [COUNT_BITS-1:0] cnt_dec;
      logic [SLOT_BITS-1:0]  old_rank;

      state_in      = state_ff;
      idx_in        = idx_ff;
      free_found_in = free_found_ff;
      free_slot_in  = free_slot_ff;
      cmd_in        = cmd_ff;
      dev_in        = dev_ff;
      blk_in        = blk_ff;
      slot_raw_in   = slot_raw_ff;
      tag_dev_in    = tag_dev_ff;
      tag_blk_in    = tag_blk_ff;
      count_in      = count_ff;
      rank_in       = rank_ff;
      order_in      = order_ff;
      valid_in      = valid_ff;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;
      fnd           = free_found_ff;
      fslot         = free_slot_ff;
      cnt_dec       = cnt_cur - 1'b1;
      old_rank      = rank_ff[op_slot];

      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in        = req_item.command;
               dev_in        = DEVICE_BITS'(req_item.device);
               blk_in        = req_item.block_number;
               slot_raw_in   = req_item.slot_in;
               idx_in        = '0;
               free_found_in = 1'b0;
               state_in      = (req_item.command == CMD_READ) ? ST_WALK : ST_UPDATE;
            end
         end

         ST_WALK: begin
            if (tag_match) begin
               // Hit: bump the count and mark the contents valid.
               count_in[walk_slot] = cnt_inc;
               valid_in[walk_slot] = 1'b1;
               rsp_in.slot_out     = 5'(walk_slot);
               rsp_in.hit          = 1'b1;
               rsp_in.needs_fill   = ~valid_ff[walk_slot];
               rsp_in.status       = STATUS_OK;
               rsp_in.count_after  = 8'(cnt_inc);
               rsp_valid_in        = 1'b1;
               state_in            = ST_IDLE;
            end else begin
               // Remember the least recent free slot seen so far.
               if (cnt_zero) begin
                  fnd   = 1'b1;
                  fslot = walk_slot;
               end
               free_found_in = fnd;
               free_slot_in  = fslot;
               if (idx_ff == LAST_RANK) begin
                  if (fnd) begin
                     tag_dev_in[fslot] = dev_ff;
                     tag_blk_in[fslot] = blk_ff;
                     count_in[fslot]   = COUNT_BITS'(1);
                     valid_in[fslot]   = 1'b1;
                     rsp_in.slot_out   = 5'(fslot);
                     rsp_in.hit        = 1'b0;
                     rsp_in.needs_fill = 1'b1;
                     rsp_in.status     = STATUS_OK;
                     rsp_in.count_after = 8'd1;
                  end else begin
                     rsp_in.slot_out    = 5'd0;
                     rsp_in.hit         = 1'b0;
                     rsp_in.needs_fill  = 1'b0;
                     rsp_in.status      = STATUS_NO_FREE;
                     rsp_in.count_after = 8'd0;
                  end
                  rsp_valid_in = 1'b1;
                  state_in     = ST_IDLE;
               end else begin
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_UPDATE: begin
            rsp_in.slot_out   = slot_raw_ff;
            rsp_in.hit        = 1'b0;
            rsp_in.needs_fill = 1'b0;
            rsp_in.status     = STATUS_OK;
            if (32'(slot_raw_ff) >= SLOT_COUNT) begin
               rsp_in.count_after = 8'd0;
            end else if (cmd_ff == CMD_PIN) begin
               count_in[op_slot]  = cnt_inc;
               rsp_in.count_after = 8'(cnt_inc);
            end else if (cnt_zero) begin
               rsp_in.status      = STATUS_UNDERFLOW;
               rsp_in.count_after = 8'd0;
            end else begin
               count_in[op_slot]  = cnt_dec;
               rsp_in.count_after = 8'(cnt_dec);
               // A release that frees the slot moves it to the front.
               if (cmd_ff == CMD_RELEASE && cnt_dec == '0) begin
                  for (int i = 0; i < SLOT_COUNT; i++) begin
                     if (rank_ff[i] < old_rank) begin
                        rank_in[i] = rank_ff[i] + 1'b1;
                     end
                     if (SLOT_BITS'(i) <= old_rank) begin
                        order_in[i] = (i == 0) ? op_slot : order_ff[(i == 0) ? 0 : i - 1];
                     end
                  end
                  rank_in[op_slot] = '0;
               end
            end
            rsp_valid_in = 1'b1;
            state_in     = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control and cache state, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         idx_ff        <= '0;
         free_found_ff <= 1'b0;
         free_slot_ff  <= '0;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         for (int i = 0; i < SLOT_COUNT; i++) begin
            tag_dev_ff[i] <= '0;
            tag_blk_ff[i] <= '0;
            count_ff[i]   <= '0;
            rank_ff[i]    <= SLOT_BITS'(SLOT_COUNT - 1 - i);
            order_ff[i]   <= SLOT_BITS'(SLOT_COUNT - 1 - i);
         end
      end else begin
         state_ff      <= state_in;
         idx_ff        <= idx_in;
         free_found_ff <= free_found_in;
         free_slot_ff  <= free_slot_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         tag_dev_ff    <= tag_dev_in;
         tag_blk_ff    <= tag_blk_in;
         count_ff      <= count_in;
         rank_ff       <= rank_in;
         order_ff      <= order_in;
      end
   end

   // Latched request and response words need no reset.
   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      dev_ff      <= dev_in;
      blk_ff      <= blk_in;
      slot_raw_ff <= slot_raw_in;
      rsp_ff      <= rsp_in;
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // The front of the recency list always holds the slot of rank zero.
   `BBC_ASSERT_SAME(a_front_rank_zero, 1'b1, rank_ff[order_ff[0]] == '0,
      "recency list and ranks disagree at the front")
   // An accepted word never produces a response in the very next cycle.
   `BBC_ASSERT_NEXT(a_no_instant_rsp, start && !busy, !rsp_valid,
      "response strobe one cycle after acceptance")
   // The response strobe appears only once the sequencer is idle again.
   `BBC_ASSERT_SAME(a_rsp_when_idle, rsp_valid, !busy,
      "response strobe while busy")

endmodule
